// ----- rtl/core/ypp_pkg.sv -----
// Shared constants, types and the sine lookup for the yaw/pitch perspective projector.
// Used by the projector top level, its pipelined divider and its port checker.
`timescale 1ns / 1ps

package ypp_pkg;

    // Screen geometry and trig lookup size.
    localparam int SCREEN_WIDTH     = 640;
    localparam int SCREEN_HEIGHT    = 480;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int MARGIN           = 50;

    // Field and datapath widths.
    localparam int COORD_W   = 32;
    localparam int ANGLE_W   = 16;
    localparam int FOCAL_W   = 32;
    localparam int DEPTH_W   = 31;
    localparam int SCR_W     = 16;
    localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
    // Table entries span -65536 to +65536, so one bit above Q16 plus the sign.
    localparam int TRIG_W    = 18;
    localparam int DELTA_W   = 33;
    localparam int PROD1_W   = 50;
    localparam int SUM1_W    = 51;
    localparam int ROT1_W    = 35;
    localparam int PROD2_W   = 52;
    localparam int ROT2_W    = 36;
    localparam int MAG_W     = 35;
    localparam int SPLIT_W   = 17;
    localparam int PPL_W     = SPLIT_W + FOCAL_W;
    localparam int PPH_W     = MAG_W - SPLIT_W + FOCAL_W;
    localparam int NUM_W     = MAG_W + FOCAL_W;
    localparam int DEN_W     = 35;
    localparam int QUO_W     = 41;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int OFFS_W    = 43;
    localparam int PIX_W     = 27;
    localparam int FRAC_W    = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_ANGLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_ANGLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH    = 3'd6;

    localparam logic [FOCAL_W-1:0] FOCAL_RESET     = 32'd32768000;
    localparam logic [DEPTH_W-1:0] MIN_DEPTH_RESET = 31'd6554;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'd16384;
    localparam logic [QUO_W-1:0]   OFFSET_CAP   = QUO_W'(1) << 40;

    localparam logic signed [OFFS_W-1:0] CENTER_X = OFFS_W'(SCREEN_WIDTH * 32768);
    localparam logic signed [OFFS_W-1:0] CENTER_Y = OFFS_W'(SCREEN_HEIGHT * 32768);
    localparam logic signed [OFFS_W-1:0] TRUNC_BIAS = OFFS_W'(65535);

    localparam logic signed [PIX_W-1:0] X_LO    = -PIX_W'(MARGIN);
    localparam logic signed [PIX_W-1:0] X_HI    = PIX_W'(SCREEN_WIDTH + MARGIN);
    localparam logic signed [PIX_W-1:0] Y_LO    = -PIX_W'(MARGIN);
    localparam logic signed [PIX_W-1:0] Y_HI    = PIX_W'(SCREEN_HEIGHT + MARGIN);
    localparam logic signed [PIX_W-1:0] SAT_MAX = PIX_W'(32767);
    localparam logic signed [PIX_W-1:0] SAT_MIN = -PIX_W'(32768);

    typedef struct packed {
        logic behind;
        logic neg_x;
        logic neg_y;
    } t_side;

    typedef struct packed {
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
        logic                    on_screen;
        logic                    behind_near;
    } t_result;

    // Sine lookup, built at elaboration: quadrant folding plus an odd Taylor series in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef logic signed [TRIG_W-1:0] t_sine_rom [SINE_TABLE_DEPTH];

    function automatic logic signed [TRIG_W-1:0] quarter_sine(input longint unsigned u);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = u * HALF_PI_Q30 / SINE_TABLE_DEPTH;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 8192) >>> 14;
        if (r > 65536) begin
            r = 65536;
        end
        return TRIG_W'(r);
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom               rom;
        longint unsigned         m;
        longint unsigned         quad;
        longint unsigned         rem;
        longint unsigned         u;
        logic signed [TRIG_W-1:0] s;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            m    = longint'(k) * 4;
            quad = m / SINE_TABLE_DEPTH;
            rem  = m % SINE_TABLE_DEPTH;
            u    = quad[0] ? longint'(SINE_TABLE_DEPTH) - rem : rem;
            s    = quarter_sine(u);
            rom[k] = quad[1] ? -s : s;
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine();

    // Table entry for a binary angle: floor(angle * depth / 65536).
    function automatic logic [IDX_W-1:0] trig_index(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W+IDX_W-1:0] prod;
        prod = (ANGLE_W+IDX_W)'(angle) * (ANGLE_W+IDX_W)'(SINE_TABLE_DEPTH);
        return IDX_W'(prod >> ANGLE_W);
    endfunction

endpackage

// ----- rtl/core/ypp_div.sv -----
// Pipelined restoring divider: one quotient bit per stage after the first, which flags quotient overflow.
// Depends on ypp_pkg for widths and latency.
`timescale 1ns / 1ps

module ypp_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ypp_pkg::NUM_W-1:0]   i_num,
    input  logic [ypp_pkg::DEN_W-1:0]   i_den,
    output logic [ypp_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_ovf
);

    localparam int QW = ypp_pkg::QUO_W;
    localparam int DW = ypp_pkg::DEN_W;
    localparam int NW = ypp_pkg::NUM_W;
    localparam int HW = NW - QW;

    // Each stage holds the partial remainder and one word that shifts numerator bits out
    // at the top while quotient bits come in at the bottom.
    logic [DW-1:0] r_rem [ypp_pkg::DIV_LAT];
    logic [QW-1:0] r_sh  [ypp_pkg::DIV_LAT];
    logic [DW-1:0] r_den [ypp_pkg::DIV_LAT];
    logic          r_ovf [ypp_pkg::DIV_LAT];

    logic [DW-1:0] n_rem [ypp_pkg::DIV_LAT];
    logic [QW-1:0] n_sh  [ypp_pkg::DIV_LAT];
    logic          n_ovf0;
    logic [HW-1:0] w_hi;
    logic [DW:0]   w_trial [ypp_pkg::DIV_LAT];
    logic          w_ge    [ypp_pkg::DIV_LAT];

    always_comb begin
        // If the top numerator bits already reach the divisor, the quotient needs more bits
        // than the datapath carries; the caller saturates it.
        w_hi       = i_num[NW-1:QW];
        n_ovf0     = DW'(w_hi) >= i_den;
        n_rem[0]   = n_ovf0 ? '0 : DW'(w_hi);
        n_sh[0]    = i_num[QW-1:0];
        w_trial[0] = '0;
        w_ge[0]    = 1'b0;
        for (int k = 1; k < ypp_pkg::DIV_LAT; k++) begin
            w_trial[k] = {r_rem[k-1], r_sh[k-1][QW-1]};
            w_ge[k]    = w_trial[k] >= {1'b0, r_den[k-1]};
            n_rem[k]   = w_ge[k] ? DW'(w_trial[k] - {1'b0, r_den[k-1]}) : DW'(w_trial[k]);
            n_sh[k]    = {r_sh[k-1][QW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_sh[0]  <= n_sh[0];
            r_den[0] <= i_den;
            r_ovf[0] <= n_ovf0;
            for (int k = 1; k < ypp_pkg::DIV_LAT; k++) begin
                r_rem[k] <= n_rem[k];
                r_sh[k]  <= n_sh[k];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_sh[ypp_pkg::DIV_LAT-1];
    assign o_ovf = r_ovf[ypp_pkg::DIV_LAT-1];

endmodule

// ----- rtl/core/yaw_pitch_perspective_projector.sv -----
// Top level of the yaw/pitch perspective projector: camera offset, two rotations, divide, center.
// Depends on ypp_pkg and instantiates two ypp_div dividers (column and row).
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// cfg       in         i_cfg_we            i_cfg_idx, i_cfg_data
// point     in         i_valid / o_stall   i_world_x, i_world_y, i_world_z
// pixel     out        o_valid / i_stall   o_screen_x, o_screen_y, o_on_screen, o_behind_near
//
// One point per clock while o_stall is low; most of the pipeline depth
// is the two restoring dividers, which produce one quotient bit per stage.
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their defaults.
// A result held by i_stall parks in a skid register; o_stall is raised only while it is full,
// and the whole pipeline then holds without losing or repeating a point.

module yaw_pitch_perspective_projector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ypp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ypp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ypp_pkg::COORD_W-1:0]  i_world_x,
    input  logic signed [ypp_pkg::COORD_W-1:0]  i_world_y,
    input  logic signed [ypp_pkg::COORD_W-1:0]  i_world_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ypp_pkg::SCR_W-1:0]    o_screen_x,
    output logic signed [ypp_pkg::SCR_W-1:0]    o_screen_y,
    output logic                                o_on_screen,
    output logic                                o_behind_near
);

    // Configuration registers.
    logic signed [ypp_pkg::COORD_W-1:0] r_cam_x;
    logic signed [ypp_pkg::COORD_W-1:0] r_cam_y;
    logic signed [ypp_pkg::COORD_W-1:0] r_cam_z;
    logic [ypp_pkg::ANGLE_W-1:0]        r_yaw;
    logic [ypp_pkg::ANGLE_W-1:0]        r_pitch;
    logic [ypp_pkg::FOCAL_W-1:0]        r_focal;
    logic [ypp_pkg::DEPTH_W-1:0]        r_min_depth;

    // Registered table lookups.
    logic signed [ypp_pkg::TRIG_W-1:0] r_sin_yaw;
    logic signed [ypp_pkg::TRIG_W-1:0] r_cos_yaw;
    logic signed [ypp_pkg::TRIG_W-1:0] r_sin_pitch;
    logic signed [ypp_pkg::TRIG_W-1:0] r_cos_pitch;

    // Pipeline stages.
    logic                               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_va;
    logic [ypp_pkg::DIV_LAT-1:0]        r_dv;
    logic signed [ypp_pkg::DELTA_W-1:0] r_dx, r_dy, r_dz;
    logic signed [ypp_pkg::PROD1_W-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [ypp_pkg::DELTA_W-1:0] r_dy2, r_dy3;
    logic signed [ypp_pkg::ROT1_W-1:0]  r_x1_3, r_z1_3, r_x1_4, r_x1_5;
    logic signed [ypp_pkg::PROD2_W-1:0] r_pe, r_pf, r_pg, r_ph;
    logic signed [ypp_pkg::ROT2_W-1:0]  r_y2, r_z2;
    logic [ypp_pkg::MAG_W-1:0]          r_ax, r_ay;
    logic [ypp_pkg::DEN_W-1:0]          r_zd6, r_zd7, r_zd8;
    ypp_pkg::t_side                     r_side6, r_side7, r_side8;
    ypp_pkg::t_side                     r_side [ypp_pkg::DIV_LAT];
    logic [ypp_pkg::PPL_W-1:0]          r_ppx_lo, r_ppy_lo;
    logic [ypp_pkg::PPH_W-1:0]          r_ppx_hi, r_ppy_hi;
    logic [ypp_pkg::NUM_W-1:0]          r_num_x, r_num_y;
    logic signed [ypp_pkg::PIX_W-1:0]   r_px, r_py;
    logic                               r_a_behind;

    // Output register and skid register.
    logic                               r_out_v, r_skid_v;
    ypp_pkg::t_result                   r_out, r_skid;

    logic                               w_adv;
    logic                               w_deliver;
    logic [ypp_pkg::QUO_W-1:0]          w_quo_x, w_quo_y;
    logic                               w_ovf_x, w_ovf_y;
    logic [ypp_pkg::QUO_W-1:0]          n_mag_x, n_mag_y;
    logic signed [ypp_pkg::OFFS_W-1:0]  n_sum_x, n_sum_y;
    logic signed [ypp_pkg::OFFS_W-1:0]  n_off_x, n_off_y;
    logic signed [ypp_pkg::PIX_W-1:0]   n_px, n_py;
    ypp_pkg::t_result                   n_fin;

    // The pipeline moves whenever the skid register is free.
    assign w_adv     = !r_skid_v;
    assign w_deliver = w_adv && r_va;
    assign o_stall   = r_skid_v;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_yaw       <= '0;
            r_pitch     <= '0;
            r_focal     <= ypp_pkg::FOCAL_RESET;
            r_min_depth <= ypp_pkg::MIN_DEPTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ypp_pkg::REG_CAMERA_X:     r_cam_x     <= i_cfg_data;
                ypp_pkg::REG_CAMERA_Y:     r_cam_y     <= i_cfg_data;
                ypp_pkg::REG_CAMERA_Z:     r_cam_z     <= i_cfg_data;
                ypp_pkg::REG_YAW_ANGLE:    r_yaw       <= i_cfg_data[ypp_pkg::ANGLE_W-1:0];
                ypp_pkg::REG_PITCH_ANGLE:  r_pitch     <= i_cfg_data[ypp_pkg::ANGLE_W-1:0];
                ypp_pkg::REG_FOCAL_LENGTH: r_focal     <= i_cfg_data;
                ypp_pkg::REG_MIN_DEPTH:    r_min_depth <= i_cfg_data[ypp_pkg::DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cosine reads the sine entry a quarter turn ahead.
    always_ff @(posedge i_clk) begin
        r_sin_yaw   <= ypp_pkg::SINE_ROM[ypp_pkg::trig_index(r_yaw)];
        r_cos_yaw   <= ypp_pkg::SINE_ROM[ypp_pkg::trig_index(r_yaw + ypp_pkg::QUARTER_TURN)];
        r_sin_pitch <= ypp_pkg::SINE_ROM[ypp_pkg::trig_index(r_pitch)];
        r_cos_pitch <= ypp_pkg::SINE_ROM[ypp_pkg::trig_index(r_pitch + ypp_pkg::QUARTER_TURN)];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_dv <= '0;
            r_va <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_dv <= {r_dv[ypp_pkg::DIV_LAT-2:0], r_v8};
            r_va <= r_dv[ypp_pkg::DIV_LAT-1];
        end
    end

    // Datapath up to the dividers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= ypp_pkg::DELTA_W'(i_world_x) - ypp_pkg::DELTA_W'(r_cam_x);
            r_dy <= ypp_pkg::DELTA_W'(i_world_y) - ypp_pkg::DELTA_W'(r_cam_y);
            r_dz <= ypp_pkg::DELTA_W'(i_world_z) - ypp_pkg::DELTA_W'(r_cam_z);

            // Yaw products.
            r_pa  <= r_cos_yaw * r_dx;
            r_pb  <= r_sin_yaw * r_dz;
            r_pc  <= r_sin_yaw * r_dx;
            r_pd  <= r_cos_yaw * r_dz;
            r_dy2 <= r_dy;

            // Arithmetic shift gives the floor of the Q16 product sum.
            r_x1_3 <= ypp_pkg::ROT1_W'((ypp_pkg::SUM1_W'(r_pa) - ypp_pkg::SUM1_W'(r_pb)) >>> 16);
            r_z1_3 <= ypp_pkg::ROT1_W'((ypp_pkg::SUM1_W'(r_pc) + ypp_pkg::SUM1_W'(r_pd)) >>> 16);
            r_dy3  <= r_dy2;

            // Pitch products.
            r_pe   <= r_cos_pitch * r_dy3;
            r_pf   <= r_sin_pitch * r_z1_3;
            r_pg   <= r_sin_pitch * r_dy3;
            r_ph   <= r_cos_pitch * r_z1_3;
            r_x1_4 <= r_x1_3;

            r_y2   <= ypp_pkg::ROT2_W'((r_pe - r_pf) >>> 16);
            r_z2   <= ypp_pkg::ROT2_W'((r_pg + r_ph) >>> 16);
            r_x1_5 <= r_x1_4;

            // Depth test and magnitudes for the unsigned divide.
            r_side6.behind <= r_z2 <= $signed({5'b0, r_min_depth});
            r_side6.neg_x  <= r_x1_5[ypp_pkg::ROT1_W-1];
            r_side6.neg_y  <= r_y2[ypp_pkg::ROT2_W-1];
            r_ax  <= r_x1_5[ypp_pkg::ROT1_W-1] ? ypp_pkg::MAG_W'(-r_x1_5) : ypp_pkg::MAG_W'(r_x1_5);
            r_ay  <= r_y2[ypp_pkg::ROT2_W-1] ? ypp_pkg::MAG_W'(-r_y2) : ypp_pkg::MAG_W'(r_y2);
            r_zd6 <= r_z2[ypp_pkg::DEN_W-1:0];

            // Magnitude times focal length, split into two partial products.
            r_ppx_lo <= r_ax[ypp_pkg::SPLIT_W-1:0] * r_focal;
            r_ppx_hi <= r_ax[ypp_pkg::MAG_W-1:ypp_pkg::SPLIT_W] * r_focal;
            r_ppy_lo <= r_ay[ypp_pkg::SPLIT_W-1:0] * r_focal;
            r_ppy_hi <= r_ay[ypp_pkg::MAG_W-1:ypp_pkg::SPLIT_W] * r_focal;
            r_side7  <= r_side6;
            r_zd7    <= r_zd6;

            r_num_x <= (ypp_pkg::NUM_W'(r_ppx_hi) << ypp_pkg::SPLIT_W) + ypp_pkg::NUM_W'(r_ppx_lo);
            r_num_y <= (ypp_pkg::NUM_W'(r_ppy_hi) << ypp_pkg::SPLIT_W) + ypp_pkg::NUM_W'(r_ppy_lo);
            r_side8 <= r_side7;
            r_zd8   <= r_zd7;

            r_side[0] <= r_side8;
            for (int k = 1; k < ypp_pkg::DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_px       <= n_px;
            r_py       <= n_py;
            r_a_behind <= r_side[ypp_pkg::DIV_LAT-1].behind;
        end
    end

    ypp_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_num_x),
        .i_den (r_zd8),
        .o_quo (w_quo_x),
        .o_ovf (w_ovf_x)
    );

    ypp_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num (r_num_y),
        .i_den (r_zd8),
        .o_quo (w_quo_y),
        .o_ovf (w_ovf_y)
    );

    // Cap the offset, reapply its sign, center it and truncate toward zero.
    always_comb begin
        n_mag_x = (w_ovf_x || w_quo_x > ypp_pkg::OFFSET_CAP) ? ypp_pkg::OFFSET_CAP : w_quo_x;
        n_mag_y = (w_ovf_y || w_quo_y > ypp_pkg::OFFSET_CAP) ? ypp_pkg::OFFSET_CAP : w_quo_y;
        n_off_x = r_side[ypp_pkg::DIV_LAT-1].neg_x ? -$signed({2'b00, n_mag_x})
                                                    : $signed({2'b00, n_mag_x});
        n_off_y = r_side[ypp_pkg::DIV_LAT-1].neg_y ? -$signed({2'b00, n_mag_y})
                                                    : $signed({2'b00, n_mag_y});
        n_sum_x = ypp_pkg::CENTER_X + n_off_x;
        n_sum_y = ypp_pkg::CENTER_Y - n_off_y;
        if (n_sum_x < 0) begin
            n_px = ypp_pkg::PIX_W'((n_sum_x + ypp_pkg::TRUNC_BIAS) >>> ypp_pkg::FRAC_W);
        end else begin
            n_px = ypp_pkg::PIX_W'(n_sum_x >>> ypp_pkg::FRAC_W);
        end
        if (n_sum_y < 0) begin
            n_py = ypp_pkg::PIX_W'((n_sum_y + ypp_pkg::TRUNC_BIAS) >>> ypp_pkg::FRAC_W);
        end else begin
            n_py = ypp_pkg::PIX_W'(n_sum_y >>> ypp_pkg::FRAC_W);
        end
    end

    // Visibility is judged before saturation; a culled point reports zeros.
    always_comb begin
        if (r_a_behind) begin
            n_fin.screen_x    = '0;
            n_fin.screen_y    = '0;
            n_fin.on_screen   = 1'b0;
            n_fin.behind_near = 1'b1;
        end else begin
            n_fin.on_screen = (r_px >= ypp_pkg::X_LO) && (r_px <= ypp_pkg::X_HI) &&
                              (r_py >= ypp_pkg::Y_LO) && (r_py <= ypp_pkg::Y_HI);
            n_fin.behind_near = 1'b0;
            if (r_px > ypp_pkg::SAT_MAX) begin
                n_fin.screen_x = ypp_pkg::SCR_W'(ypp_pkg::SAT_MAX);
            end else if (r_px < ypp_pkg::SAT_MIN) begin
                n_fin.screen_x = ypp_pkg::SCR_W'(ypp_pkg::SAT_MIN);
            end else begin
                n_fin.screen_x = ypp_pkg::SCR_W'(r_px);
            end
            if (r_py > ypp_pkg::SAT_MAX) begin
                n_fin.screen_y = ypp_pkg::SCR_W'(ypp_pkg::SAT_MAX);
            end else if (r_py < ypp_pkg::SAT_MIN) begin
                n_fin.screen_y = ypp_pkg::SCR_W'(ypp_pkg::SAT_MIN);
            end else begin
                n_fin.screen_y = ypp_pkg::SCR_W'(r_py);
            end
        end
    end

    // Output and skid control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= w_deliver;
            end
        end else if (w_deliver) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out <= r_skid;
            end else if (w_deliver) begin
                r_out <= n_fin;
            end
        end else if (w_deliver) begin
            r_skid <= n_fin;
        end
    end

    assign o_valid       = r_out_v;
    assign o_screen_x    = r_out.screen_x;
    assign o_screen_y    = r_out.screen_y;
    assign o_on_screen   = r_out.on_screen;
    assign o_behind_near = r_out.behind_near;

endmodule

// ----- rtl/core/ypp_checker.sv -----
// Port-level checker for the yaw/pitch perspective projector, attached by bind.
// Depends on ypp_pkg for the screen limits.
`timescale 1ns / 1ps

module ypp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_stall,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic signed [ypp_pkg::SCR_W-1:0] o_screen_x,
    input logic signed [ypp_pkg::SCR_W-1:0] o_screen_y,
    input logic                             o_on_screen,
    input logic                             o_behind_near
);

    // A culled point carries zero coordinates and is never visible.
    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_behind_near |-> o_screen_x == 0 && o_screen_y == 0 && !o_on_screen)
        else $error("culled point with nonzero coordinates or visible");

    // A visible point lies inside the screen plus margin, so saturation never touched it.
    a_visible_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_on_screen |->
            o_screen_x >= -ypp_pkg::MARGIN &&
            o_screen_x <= ypp_pkg::SCREEN_WIDTH + ypp_pkg::MARGIN &&
            o_screen_y >= -ypp_pkg::MARGIN &&
            o_screen_y <= ypp_pkg::SCREEN_HEIGHT + ypp_pkg::MARGIN)
        else $error("visible point outside the margin");

    // The input side stalls only after a result was held on the output side.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("input stall without a held result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("handshake active after reset");

endmodule

bind yaw_pitch_perspective_projector ypp_checker u_ypp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_stall       (i_stall),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .o_screen_x    (o_screen_x),
    .o_screen_y    (o_screen_y),
    .o_on_screen   (o_on_screen),
    .o_behind_near (o_behind_near)
);

// ----- test/yaw_pitch_perspective_projector_test.sv -----
// Self-checking testbench for the yaw/pitch perspective projector.
// Depends on ypp_pkg and the projector RTL; predicts each pixel with its own integer model.
`timescale 1ns / 1ps

module yaw_pitch_perspective_projector_test;

    localparam logic [ypp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 64;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [ypp_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [ypp_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [ypp_pkg::COORD_W-1:0]  i_world_x = '0;
    logic signed [ypp_pkg::COORD_W-1:0]  i_world_y = '0;
    logic signed [ypp_pkg::COORD_W-1:0]  i_world_z = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [ypp_pkg::SCR_W-1:0]    o_screen_x;
    logic signed [ypp_pkg::SCR_W-1:0]    o_screen_y;
    logic                                o_on_screen;
    logic                                o_behind_near;

    yaw_pitch_perspective_projector DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Copy of the camera registers as the block should hold them.
    logic signed [ypp_pkg::COORD_W-1:0] cam_x, cam_y, cam_z;
    logic [ypp_pkg::ANGLE_W-1:0]        yaw, pitch;
    logic [ypp_pkg::FOCAL_W-1:0]        focal;
    logic [ypp_pkg::DEPTH_W-1:0]        near_limit;

    longint             sine_tab [ypp_pkg::SINE_TABLE_DEPTH];
    ypp_pkg::t_result   pixel_queue [$];
    int                 error_count = 0;
    int                 hold_cycles = 0;
    int                 rx_mode = 0;
    int                 burst_left = 0;

    function automatic longint quarter_wave(longint unsigned u);
        longint unsigned x, term;
        longint          acc, r;
        x    = u * 64'd1686629713 / ypp_pkg::SINE_TABLE_DEPTH;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) acc = 0;
        r = (acc + 8192) >>> 14;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    task automatic fill_sine_table();
        longint unsigned m, quad, rem, u;
        longint          s;
        for (int k = 0; k < ypp_pkg::SINE_TABLE_DEPTH; k++) begin
            m    = 4 * k;
            quad = m / ypp_pkg::SINE_TABLE_DEPTH;
            rem  = m % ypp_pkg::SINE_TABLE_DEPTH;
            u    = quad[0] ? ypp_pkg::SINE_TABLE_DEPTH - rem : rem;
            s    = quarter_wave(u);
            sine_tab[k] = quad[1] ? -s : s;
        end
    endtask

    function automatic longint sine_at(logic [ypp_pkg::ANGLE_W-1:0] a);
        longint idx;
        idx = (longint'(a) * ypp_pkg::SINE_TABLE_DEPTH) >> 16;
        if (idx >= ypp_pkg::SINE_TABLE_DEPTH) idx = ypp_pkg::SINE_TABLE_DEPTH - 1;
        return sine_tab[idx];
    endfunction

    function automatic longint cosine_at(logic [ypp_pkg::ANGLE_W-1:0] a);
        logic [ypp_pkg::ANGLE_W-1:0] shifted;
        shifted = a + ypp_pkg::QUARTER_TURN;
        return sine_at(shifted);
    endfunction

    // Signed num * focal / depth with the magnitude truncated and capped at 2^40.
    function automatic longint scaled_offset(longint num, longint unsigned depth);
        longint unsigned mag_in, fh, fl, prod, qa, ra, mag;
        mag_in = (num < 0) ? longint'(-num) : longint'(num);
        fh   = focal >> 16;
        fl   = focal & 32'h0000_FFFF;
        prod = mag_in * fh;
        qa   = prod / depth;
        ra   = prod % depth;
        if (qa >= (64'd1 << 24)) begin
            mag = 64'd1 << 40;
        end else begin
            mag = (qa << 16) + ((ra << 16) + mag_in * fl) / depth;
            if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
        end
        return (num < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [ypp_pkg::SCR_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return ypp_pkg::SCR_W'(v);
    endfunction

    function automatic ypp_pkg::t_result project_point(
            logic signed [ypp_pkg::COORD_W-1:0] wx,
            logic signed [ypp_pkg::COORD_W-1:0] wy,
            logic signed [ypp_pkg::COORD_W-1:0] wz);
        longint           dx, dy, dz, cy, sy, cp, sp, x1, z1, y2, z2, ox, oy, px, py;
        ypp_pkg::t_result res;
        dx = longint'(wx) - longint'(cam_x);
        dy = longint'(wy) - longint'(cam_y);
        dz = longint'(wz) - longint'(cam_z);
        cy = cosine_at(yaw);
        sy = sine_at(yaw);
        x1 = (cy * dx - sy * dz) >>> 16;
        z1 = (sy * dx + cy * dz) >>> 16;
        cp = cosine_at(pitch);
        sp = sine_at(pitch);
        y2 = (cp * dy - sp * z1) >>> 16;
        z2 = (sp * dy + cp * z1) >>> 16;
        if (z2 <= longint'(near_limit)) begin
            res = '{screen_x: '0, screen_y: '0, on_screen: 1'b0, behind_near: 1'b1};
            return res;
        end
        ox = scaled_offset(x1, z2);
        oy = scaled_offset(y2, z2);
        px = (longint'(ypp_pkg::SCREEN_WIDTH) * 32768 + ox) / 65536;
        py = (longint'(ypp_pkg::SCREEN_HEIGHT) * 32768 - oy) / 65536;
        res.screen_x    = clamp16(px);
        res.screen_y    = clamp16(py);
        res.on_screen   = (px >= -ypp_pkg::MARGIN) &&
                          (px <= ypp_pkg::SCREEN_WIDTH + ypp_pkg::MARGIN) &&
                          (py >= -ypp_pkg::MARGIN) &&
                          (py <= ypp_pkg::SCREEN_HEIGHT + ypp_pkg::MARGIN);
        res.behind_near = 1'b0;
        return res;
    endfunction

    // Compare each pixel transfer with the oldest prediction.
    always @(posedge i_clk) begin
        ypp_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d", $time, o_screen_x, o_screen_y);
                error_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (o_screen_x !== want.screen_x) begin
                    $display("%0t: screen_x expected %0d actual %0d",
                             $time, want.screen_x, o_screen_x);
                    error_count++;
                end
                if (o_screen_y !== want.screen_y) begin
                    $display("%0t: screen_y expected %0d actual %0d",
                             $time, want.screen_y, o_screen_y);
                    error_count++;
                end
                if (o_on_screen !== want.on_screen) begin
                    $display("%0t: on_screen expected %0b actual %0b",
                             $time, want.on_screen, o_on_screen);
                    error_count++;
                end
                if (o_behind_near !== want.behind_near) begin
                    $display("%0t: behind_near expected %0b actual %0b",
                             $time, want.behind_near, o_behind_near);
                    error_count++;
                end
            end
        end
    end

    // Receiver: a long hold when asked, otherwise a stall pattern chosen by rx_mode.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            case (rx_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 7) < 6);
            endcase
        end
    end

    task automatic send_point(logic signed [ypp_pkg::COORD_W-1:0] wx,
                              logic signed [ypp_pkg::COORD_W-1:0] wy,
                              logic signed [ypp_pkg::COORD_W-1:0] wz);
        i_valid   <= 1'b1;
        i_world_x <= wx;
        i_world_y <= wy;
        i_world_z <= wz;
        do @(posedge i_clk); while (o_stall);
        pixel_queue.push_back(project_point(wx, wy, wz));
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        idle_cycles(1);
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ypp_pkg::CFG_IDX_W-1:0] idx,
                             logic [ypp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            ypp_pkg::REG_CAMERA_X:     cam_x = data;
            ypp_pkg::REG_CAMERA_Y:     cam_y = data;
            ypp_pkg::REG_CAMERA_Z:     cam_z = data;
            ypp_pkg::REG_YAW_ANGLE:    yaw = data[ypp_pkg::ANGLE_W-1:0];
            ypp_pkg::REG_PITCH_ANGLE:  pitch = data[ypp_pkg::ANGLE_W-1:0];
            ypp_pkg::REG_FOCAL_LENGTH: focal = data;
            ypp_pkg::REG_MIN_DEPTH:    near_limit = data[ypp_pkg::DEPTH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] yw, logic [31:0] pt, logic [31:0] fl,
                              logic [31:0] nd);
        wait_drain();
        write_reg(ypp_pkg::REG_CAMERA_X, cx);
        write_reg(ypp_pkg::REG_CAMERA_Y, cy);
        write_reg(ypp_pkg::REG_CAMERA_Z, cz);
        write_reg(ypp_pkg::REG_YAW_ANGLE, yw);
        write_reg(ypp_pkg::REG_PITCH_ANGLE, pt);
        write_reg(ypp_pkg::REG_FOCAL_LENGTH, fl);
        write_reg(ypp_pkg::REG_MIN_DEPTH, nd);
        write_reg(REG_UNUSED, $urandom());
        i_cfg_we <= 1'b0;
    endtask

    // Mostly points near the camera with a forward bias, plus raw noise.
    task automatic random_point(output logic signed [ypp_pkg::COORD_W-1:0] wx,
                                output logic signed [ypp_pkg::COORD_W-1:0] wy,
                                output logic signed [ypp_pkg::COORD_W-1:0] wz);
        case ($urandom_range(0, 9))
            0, 1: begin
                wx = $urandom();
                wy = $urandom();
                wz = $urandom();
            end
            9: begin
                wx = cam_x + $signed($urandom_range(0, 8191)) - 4096;
                wy = cam_y + $signed($urandom_range(0, 8191)) - 4096;
                wz = cam_z + $signed($urandom_range(0, 16383)) - 4096;
            end
            default: begin
                wx = cam_x + $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                wy = cam_y + $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
                wz = cam_z + $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0040_0000;
            end
        endcase
    endtask

    task automatic send_stream(int count);
        logic signed [ypp_pkg::COORD_W-1:0] wx, wy, wz;
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
            end
            burst_left--;
            random_point(wx, wy, wz);
            send_point(wx, wy, wz);
        end
    endtask

    task automatic test_directed_points();
        rx_mode = 0;
        send_point(0, 0, 0);
        send_point(0, 0, 6554);
        send_point(0, 0, 6555);
        send_point(0, 0, 500 << 16);
        // Points landing exactly on and just past the margin at depth equal to the focal length.
        send_point(-(370 << 16), 0, 500 << 16);
        send_point(-(371 << 16), 0, 500 << 16);
        send_point(370 << 16, 0, 500 << 16);
        send_point(371 << 16, 0, 500 << 16);
        send_point(0, 290 << 16, 500 << 16);
        send_point(0, 291 << 16, 500 << 16);
        send_point(0, -(290 << 16), 500 << 16);
        send_point(0, -(291 << 16), 500 << 16);
        // Small negative column truncates toward zero.
        send_point(-(320 << 16) - 1, 0, 500 << 16);
        // Saturation and the offset cap.
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 6555);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 6555);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(-1, -1, -1);
        send_point(1, 1, 1);
    endtask

    task automatic test_camera_settings();
        set_camera(0, 0, 0, 16384, 0, ypp_pkg::FOCAL_RESET, ypp_pkg::MIN_DEPTH_RESET);
        rx_mode = 1;
        send_stream(60);
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32768, 16384, 0, 0);
        send_stream(60);
        set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 65535, 65535,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        rx_mode = 2;
        send_stream(60);
        set_camera(32'h0010_0000, 32'hFFF0_0000, 32'hFFC0_0000, 49152, 32768,
                   32'h0001_0000, 32'h8000_0001);
        send_stream(60);
        set_camera(0, 0, 0, 0, 49152, ypp_pkg::FOCAL_RESET, 1);
        rx_mode = 3;
        send_stream(60);
        set_camera($urandom(), $urandom(), $urandom(), 16'hFFFF, 16'h0000,
                   $urandom(), 32'h0000_0000);
        send_stream(60);
    endtask

    task automatic test_backpressure();
        set_camera(0, 0, 0, $urandom_range(0, 4096), $urandom_range(0, 4096),
                   ypp_pkg::FOCAL_RESET, ypp_pkg::MIN_DEPTH_RESET);
        rx_mode = 0;
        hold_cycles = 300;
        send_stream(200);
        rx_mode = 2;
        // Let everything come out before offering more.
        wait_drain();
        send_stream(80);
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 9; phase++) begin
            set_camera($urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31),
                       $urandom() >> $urandom_range(0, 31), $urandom(), $urandom(),
                       $urandom() >> $urandom_range(0, 31), $urandom() >> $urandom_range(0, 31));
            rx_mode = phase % 4;
            send_stream(60);
        end
    endtask

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        fill_sine_table();
        cam_x = 0;
        cam_y = 0;
        cam_z = 0;
        yaw = 0;
        pitch = 0;
        focal = ypp_pkg::FOCAL_RESET;
        near_limit = ypp_pkg::MIN_DEPTH_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_points();
        test_camera_settings();
        test_backpressure();
        test_random_stream();
        wait_drain();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
